// ===== rtl/core/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Hamming SEC codec package
// Shared widths, mode codes and the check-bit count and data-length functions.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int WORD_W            = 64;
  localparam int DATA_W            = 57;
  localparam int POS_W             = 7;
  localparam int CFG_W             = 6;
  localparam int MAX_CODE_BITS_DEF = 64;
  localparam int RESET_DATA_BITS   = 4;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // least r >= 1 with 2^r >= n + r + 1, capped at 7
  function automatic logic [2:0] check_count(input logic [6:0] n);
    logic [2:0] r;
    logic       done;
    r    = 3'd1;
    done = 1'b0;
    for (int k = 1; k < 7; k++) begin
      if (!done && ((8'd1 << k) < ({1'b0, n} + 8'(k) + 8'd1))) begin
        r = 3'(k + 1);
      end else begin
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // largest data length whose codeword fits in max_bits
  function automatic int max_data_len(input int max_bits);
    int best;
    best = 1;
    for (int n = 1; n < 64; n++) begin
      if (n + int'(check_count(7'(n))) <= max_bits) begin
        best = n;
      end
    end
    return best;
  endfunction

  // raw register value to effective data length: zero reads as one, clamp to nmax
  function automatic logic [6:0] eff_data_len(input logic [CFG_W-1:0] raw, input int nmax);
    logic [6:0] n;
    n = (raw == '0) ? 7'd1 : {1'b0, raw};
    if (n > 7'(nmax)) begin
      n = 7'(nmax);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/hsc_if.sv =====
// ----------------------------------------------------------------------------
// Hamming SEC codec channels
// Valid/ready request and result channels with their payloads.
// ----------------------------------------------------------------------------
interface hsc_req_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [WORD_W-1:0] word;

  modport source (output valid, output mode, output word, input ready);
  modport sink   (input valid, input mode, input word, output ready);
endinterface

interface hsc_rsp_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] codeword;
  logic [DATA_W-1:0] data_out;
  logic [POS_W-1:0]  error_position;
  logic              error_beyond_length;

  modport source (output valid, output codeword, output data_out, output error_position,
                  output error_beyond_length, input ready);
  modport sink   (input valid, input codeword, input data_out, input error_position,
                  input error_beyond_length, output ready);
endinterface

// ===== rtl/core/hamming_sec_codec_unit.sv =====
// ----------------------------------------------------------------------------
// Hamming SEC codec unit
// Configurable-length even-parity Hamming encoder and single-error corrector.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------------------
//  request   | in  | valid/ready  | mode, word
//  result    | out | valid/ready  | codeword, data_out, error_position,
//            |     |              | error_beyond_length
//  cfg       | in  | cfg_we       | cfg_data (data length)
//
//  One item per cycle while the result channel is not stalled; an accepted request
//  passes through the input register and then the result register around the
//  single-pass parity and correction logic.
//  rst is synchronous: clears both stages and returns the data length to 4.
//  A stalled result holds its register; the input stage keeps taking items
//  while the result stage can move on.
// ----------------------------------------------------------------------------
module hamming_sec_codec_unit import hsc_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  hsc_req_if.sink          request,
  hsc_rsp_if.source        result
);

  localparam int CW    = MAX_CODE_BITS;
  localparam int NMAX  = max_data_len(CW);
  localparam int LEN_W = $clog2(CW + 1);
  localparam int N_W   = $clog2(NMAX + 1);
  localparam logic [6:0] RESET_N = eff_data_len(CFG_W'(RESET_DATA_BITS), NMAX);

  logic [N_W-1:0]   data_len;
  logic [LEN_W-1:0] code_len;
  logic [6:0]       cfg_n;

  logic             req_valid;
  logic             req_mode;
  logic [CW-1:0]    req_word;

  logic             rsp_valid;
  logic [CW-1:0]    cw_q;
  logic [NMAX-1:0]  data_q;
  logic [LEN_W-1:0] syn_q;
  logic             beyond_q;

  logic             out_en;
  logic [CW-1:0]    dp_cw;
  logic [NMAX-1:0]  dp_data;
  logic [LEN_W-1:0] dp_syn;
  logic             dp_beyond;

  assign cfg_n  = eff_data_len(cfg_data, NMAX);
  assign out_en = !rsp_valid || result.ready;
  assign request.ready = !req_valid || out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_len  <= N_W'(RESET_N);
      code_len  <= LEN_W'(RESET_N + 7'(check_count(RESET_N)));
      req_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        data_len <= N_W'(cfg_n);
        code_len <= LEN_W'(cfg_n + 7'(check_count(cfg_n)));
      end
      if (request.ready) begin
        req_valid <= request.valid;
      end
      if (out_en) begin
        rsp_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      req_mode <= request.mode;
      req_word <= request.word[CW-1:0];
    end
    if (out_en && req_valid) begin
      cw_q     <= dp_cw;
      data_q   <= dp_data;
      syn_q    <= dp_syn;
      beyond_q <= dp_beyond;
    end
  end

  hsc_datapath #(
    .CODE_W (CW)
  ) u_datapath (
    .mode     (req_mode),
    .word     (req_word),
    .data_len (data_len),
    .code_len (code_len),
    .codeword (dp_cw),
    .data     (dp_data),
    .syndrome (dp_syn),
    .beyond   (dp_beyond)
  );

  assign result.valid               = rsp_valid;
  assign result.codeword            = WORD_W'(cw_q);
  assign result.data_out            = DATA_W'(data_q);
  assign result.error_position      = POS_W'(syn_q);
  assign result.error_beyond_length = beyond_q;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    (data_len != '0) && (data_len <= N_W'(NMAX)))
    else $error("data length out of range");

  a_code_len: assert property (@(posedge clk) disable iff (rst)
    code_len == LEN_W'(7'(data_len) + 7'(check_count(7'(data_len)))))
    else $error("codeword length does not match data length");

  a_beyond_syn: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && beyond_q |-> (syn_q != '0) && (syn_q > code_len))
    else $error("beyond-length flag without a syndrome past the codeword");

  a_cw_masked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((cw_q >> code_len) == '0))
    else $error("codeword bits set past codeword length");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> req_valid)
    else $error("accepted item lost at input stage");
`endif

endmodule

// ===== rtl/core/hsc_datapath.sv =====
// ----------------------------------------------------------------------------
// Hamming SEC codec datapath
// Single-pass encode and decode: spread, syndrome trees, correction, extract.
// ----------------------------------------------------------------------------
module hsc_datapath import hsc_pkg::*; #(
  parameter int CODE_W = MAX_CODE_BITS_DEF,
  localparam int NMAX  = max_data_len(CODE_W),
  localparam int LEN_W = $clog2(CODE_W + 1),
  localparam int N_W   = $clog2(NMAX + 1)
) (
  input  logic              mode,
  input  logic [CODE_W-1:0] word,
  input  logic [N_W-1:0]    data_len,
  input  logic [LEN_W-1:0]  code_len,
  output logic [CODE_W-1:0] codeword,
  output logic [NMAX-1:0]   data,
  output logic [LEN_W-1:0]  syndrome,
  output logic              beyond
);

  logic [CODE_W-1:0] len_mask;
  logic [NMAX-1:0]   data_mask;
  logic [CODE_W-1:0] spread;
  logic [CODE_W-1:0] masked;
  logic [CODE_W-1:0] parity_src;
  logic [LEN_W-1:0]  syn;
  logic [CODE_W-1:0] enc_cw;
  logic [CODE_W-1:0] flip;
  logic              syn_beyond;
  int                di;
  int                ci;
  int                ki;

  always_comb begin
    for (int b = 0; b < CODE_W; b++) begin
      len_mask[b] = (LEN_W'(b) < code_len);
    end
    for (int j = 0; j < NMAX; j++) begin
      data_mask[j] = (N_W'(j) < data_len);
    end
  end

  assign masked = word & len_mask;

  // place data bits over non-power-of-two positions
  always_comb begin
    spread = '0;
    di     = 0;
    for (int b = 0; b < CODE_W; b++) begin
      if (((b + 1) & b) != 0) begin
        if (di < NMAX) begin
          spread[b] = word[di] & data_mask[di];
        end
        di++;
      end
    end
  end

  assign parity_src = (mode == MODE_DECODE) ? masked : spread;

  always_comb begin
    for (int i = 0; i < LEN_W; i++) begin
      syn[i] = 1'b0;
      for (int b = 0; b < CODE_W; b++) begin
        if ((((b + 1) >> i) & 1) != 0) begin
          syn[i] = syn[i] ^ parity_src[b];
        end
      end
    end
  end

  // fill check bits at power-of-two positions
  always_comb begin
    enc_cw = spread;
    ci     = 0;
    for (int b = 0; b < CODE_W; b++) begin
      if (((b + 1) & b) == 0) begin
        enc_cw[b] = syn[ci] & len_mask[b];
        ci++;
      end
    end
  end

  assign syn_beyond = (syn != '0) && (syn > code_len);

  always_comb begin
    for (int b = 0; b < CODE_W; b++) begin
      flip[b] = !syn_beyond && (syn == LEN_W'(b + 1));
    end
  end

  assign codeword = (mode == MODE_DECODE) ? (masked ^ flip) : enc_cw;
  assign syndrome = (mode == MODE_DECODE) ? syn : '0;
  assign beyond   = (mode == MODE_DECODE) && syn_beyond;

  always_comb begin
    data = '0;
    ki   = 0;
    for (int b = 0; b < CODE_W; b++) begin
      if (((b + 1) & b) != 0) begin
        if (ki < NMAX) begin
          data[ki] = codeword[b] & data_mask[ki];
        end
        ki++;
      end
    end
  end

endmodule
